FILE: sv/ppu_pkg.sv
// Shared types, constants and codes for the particle pool update block.
package ppu_pkg;

  localparam int POOL_DEPTH_DEF = 64;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int GRAV_W         = 24;

  localparam logic [PADDR_W-1:0] ADDR_GRAVITY  = 3'd0;
  localparam logic [GRAV_W-1:0]  GRAVITY_RESET = 24'd786432;

  localparam logic [16:0] RATIO_ONE  = 17'd65536;
  localparam logic [16:0] SIZE_BASE  = 17'd64225;
  localparam logic [10:0] SIZE_SLOPE = 11'd1311;
  localparam logic [7:0]  ALPHA_MAX  = 8'd255;
  localparam logic [15:0] HALF_LSB   = 16'd32768;

  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_LIST  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAWN,
    S_RESP,
    S_GRAV,
    S_RD,
    S_LD,
    S_MUL,
    S_POS,
    S_DIV,
    S_FAC,
    S_WR,
    S_TDONE,
    S_LRD,
    S_LOUT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] spawn_pos_x;
    logic signed [31:0] spawn_pos_y;
    logic signed [31:0] spawn_pos_z;
    logic signed [23:0] spawn_vel_x;
    logic signed [23:0] spawn_vel_y;
    logic signed [23:0] spawn_vel_z;
    logic [31:0]        spawn_rgba;
    logic [15:0]        spawn_life;
    logic [15:0]        spawn_size;
    logic [15:0]        time_step;
  } request_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic [31:0]        out_rgba;
    logic [15:0]        out_size;
    logic               has_particle;
    logic [6:0]         live_count;
    logic               spawn_dropped;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [31:0]        rgba;
    logic [15:0]        life;
    logic [15:0]        init_life;
    logic [15:0]        size;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } div_stat_t;

endpackage

FILE: sv/ppu_mem.sv
// Particle store: one write port, one read port with registered read data.
module ppu_mem #(
  parameter int DEPTH = ppu_pkg::POOL_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  ppu_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output ppu_pkg::entry_t  rdata
);

  ppu_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ppu_div.sv
// Iterative life ratio divider: (life << 16) / init_life, clamped to 1.0; zero for a zero init_life.
module ppu_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        life,
  input  logic [15:0]        init_life,
  output ppu_pkg::div_stat_t stat,
  output logic [16:0]        ratio
);

  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] divisor;
  logic [3:0]  cnt;
  logic [16:0] rem_sh;
  logic        fits;
  logic [15:0] quo_next;
  logic        quick;

  always_comb begin
    rem_sh   = {rem, 1'b0};
    fits     = (rem_sh >= {1'b0, divisor});
    quo_next = {quo[14:0], fits};
    // zero divisor or a ratio of at least one needs no iterations
    quick    = (init_life == 16'd0) || (life >= init_life);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (start) begin
      stat <= '{busy: !quick, valid: quick};
      if (init_life == 16'd0) begin
        ratio <= '0;
      end else if (life >= init_life) begin
        ratio <= ppu_pkg::RATIO_ONE;
      end else begin
        rem     <= life;
        quo     <= '0;
        divisor <= init_life;
        cnt     <= '0;
      end
    end else if (stat.busy) begin
      // one quotient bit a cycle
      rem <= fits ? 16'(rem_sh - {1'b0, divisor}) : rem_sh[15:0];
      quo <= quo_next;
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        stat  <= '{busy: 1'b0, valid: 1'b1};
        ratio <= {1'b0, quo_next};
      end
    end
  end

endmodule

FILE: sv/particle_pool_update.sv
// Top level of the particle pool: request decode, Euler step sequencer, APB register.
//
//   channel   dir  handshake                 payload
//   request   in   request_valid/ready       ppu_pkg::request_t
//   result    out  result_valid/ready        ppu_pkg::result_t
//   apb       in   psel/penable/pwrite       paddr, pwdata, prdata (gravity_accel)
//
// A spawn passes S_SPAWN and S_RESP; an unknown operation or an empty list goes
// straight to S_RESP; a list reads and outputs each particle (S_LRD, S_LOUT). A tick
// sets the gravity step in S_GRAV, reads each particle (S_RD, S_LD), drops an expired
// one and takes a survivor through S_MUL, S_POS, S_DIV (waiting on the 16-step divider
// unless life is at or above initial life or initial life is zero), S_FAC and S_WR.
// Reset clears the pool count and the control registers; the store itself is never cleared
// since only entries below the count are read. A stalled result port holds the
// sequencer only where it has a result to load; one finished result may wait in the
// output register while the next request is taken.
module particle_pool_update #(
  parameter int POOL_DEPTH = ppu_pkg::POOL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          request_valid,
  output logic                          request_ready,
  input  ppu_pkg::request_t             request,
  output logic                          result_valid,
  input  logic                          result_ready,
  output ppu_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppu_pkg::PADDR_W-1:0]   paddr,
  input  logic [ppu_pkg::PDATA_W-1:0]   pwdata,
  output logic [ppu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);

  ppu_pkg::state_t state, state_next;

  logic [ppu_pkg::GRAV_W-1:0] gravity_accel;
  ppu_pkg::request_t          req_q;
  logic [CW-1:0]              count;
  logic [CW-1:0]              ri;
  logic [CW-1:0]              wi;
  logic                       drop;
  logic [23:0]                dv;
  ppu_pkg::entry_t            ent;
  logic signed [23:0]         vy;
  logic [15:0]                life_n;
  logic signed [24:0]         dpx, dpy, dpz;
  logic [16:0]                ratio;
  logic [7:0]                 alpha;
  logic [16:0]                factor;

  // APB register: always ready, gravity at the only address
  assign pready = 1'b1;
  assign prdata = (paddr == ppu_pkg::ADDR_GRAVITY) ?
                  {{(ppu_pkg::PDATA_W - ppu_pkg::GRAV_W){1'b0}}, gravity_accel} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_accel <= ppu_pkg::GRAVITY_RESET;
    end else if (psel && penable && pwrite && paddr == ppu_pkg::ADDR_GRAVITY) begin
      gravity_accel <= pwdata[ppu_pkg::GRAV_W-1:0];
    end
  end

  // store and divider
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr;
  ppu_pkg::entry_t       mem_wdata, mem_rdata;
  logic                  div_start;
  ppu_pkg::div_stat_t    div_stat;
  logic [16:0]           div_ratio;

  ppu_mem #(.DEPTH(POOL_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (ri[AW-1:0]),
    .rdata (mem_rdata)
  );

  // step arithmetic on the freshly read entry
  logic [14:0]        dlife;
  logic signed [25:0] vy_wide;
  logic signed [23:0] vy_sat;
  logic signed [16:0] life_wide;
  logic               alive;

  always_comb begin
    dlife     = 15'((17'(req_q.time_step) + 17'd3) >> 2);
    vy_wide   = 26'(mem_rdata.vel_y) - $signed({2'b00, dv});
    if (vy_wide > 26'sd8388607) begin
      vy_sat = 24'sd8388607;
    end else if (vy_wide < -26'sd8388608) begin
      vy_sat = -24'sd8388608;
    end else begin
      vy_sat = 24'(vy_wide);
    end
    life_wide = $signed({1'b0, mem_rdata.life}) - $signed({2'b00, dlife});
    alive     = (life_wide > 17'sd0);
  end

  ppu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .life      (life_wide[15:0]),
    .init_life (mem_rdata.init_life),
    .stat      (div_stat),
    .ratio     (div_ratio)
  );

  // per-axis products, gravity, alpha, factor and size
  logic signed [40:0] px, py, pz;
  logic [39:0]        grav_prod;
  logic [24:0]        alpha_prod;
  logic [27:0]        slope_prod;
  logic [32:0]        size_prod;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [24:0] d);
    logic signed [32:0] s;
    s = 33'(p) + 33'(d);
    if (s > 33'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(s);
  endfunction

  // entry with its position advanced by the registered deltas
  ppu_pkg::entry_t ent_moved;

  always_comb begin
    ent_moved       = ent;
    ent_moved.pos_x = sat_add(ent.pos_x, dpx);
    ent_moved.pos_y = sat_add(ent.pos_y, dpy);
    ent_moved.pos_z = sat_add(ent.pos_z, dpz);
  end

  always_comb begin
    px         = $signed(ent.vel_x) * $signed({1'b0, req_q.time_step});
    py         = $signed(vy) * $signed({1'b0, req_q.time_step});
    pz         = $signed(ent.vel_z) * $signed({1'b0, req_q.time_step});
    grav_prod  = 40'(gravity_accel) * 40'(req_q.time_step);
    alpha_prod = 25'(ratio) * 25'(ppu_pkg::ALPHA_MAX);
    slope_prod = 28'(ratio) * 28'(ppu_pkg::SIZE_SLOPE);
    size_prod  = 33'(ent.size) * 33'(factor);
  end

  logic last_idx;
  logic slot_free;
  assign last_idx  = ((ri + CW'(1)) == count);
  assign slot_free = !result_valid || result_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ppu_pkg::S_IDLE: begin
        if (request_valid) begin
          case (request.operation)
            ppu_pkg::OP_SPAWN: state_next = ppu_pkg::S_SPAWN;
            ppu_pkg::OP_TICK:  state_next = ppu_pkg::S_GRAV;
            ppu_pkg::OP_LIST:
              state_next = (count != '0) ? ppu_pkg::S_LRD : ppu_pkg::S_RESP;
            default:           state_next = ppu_pkg::S_RESP;
          endcase
        end
      end
      ppu_pkg::S_SPAWN: state_next = ppu_pkg::S_RESP;
      ppu_pkg::S_RESP:  if (slot_free) state_next = ppu_pkg::S_IDLE;
      ppu_pkg::S_GRAV:  state_next = (count != '0) ? ppu_pkg::S_RD : ppu_pkg::S_TDONE;
      ppu_pkg::S_RD:    state_next = ppu_pkg::S_LD;
      ppu_pkg::S_LD: begin
        if (alive) begin
          state_next = ppu_pkg::S_MUL;
        end else begin
          state_next = last_idx ? ppu_pkg::S_TDONE : ppu_pkg::S_RD;
        end
      end
      ppu_pkg::S_MUL:   state_next = ppu_pkg::S_POS;
      ppu_pkg::S_POS:   state_next = ppu_pkg::S_DIV;
      ppu_pkg::S_DIV:   if (div_stat.valid) state_next = ppu_pkg::S_FAC;
      ppu_pkg::S_FAC:   state_next = ppu_pkg::S_WR;
      ppu_pkg::S_WR:    state_next = last_idx ? ppu_pkg::S_TDONE : ppu_pkg::S_RD;
      ppu_pkg::S_TDONE: state_next = ppu_pkg::S_RESP;
      ppu_pkg::S_LRD:   state_next = ppu_pkg::S_LOUT;
      ppu_pkg::S_LOUT: begin
        if (slot_free) state_next = last_idx ? ppu_pkg::S_IDLE : ppu_pkg::S_LRD;
      end
      default:          state_next = ppu_pkg::S_IDLE;
    endcase
  end

  // control outputs; the write index never passes the read index, so a write-back
  // cannot hit an entry that is still to be read
  always_comb begin
    request_ready = (state == ppu_pkg::S_IDLE);
    mem_re        = (state == ppu_pkg::S_RD) || (state == ppu_pkg::S_LRD);
    div_start     = (state == ppu_pkg::S_LD) && alive;
    mem_we        = ((state == ppu_pkg::S_SPAWN) && (count != CW'(POOL_DEPTH))) ||
                    (state == ppu_pkg::S_WR);
    if (state == ppu_pkg::S_SPAWN) begin
      mem_waddr           = count[AW-1:0];
      mem_wdata.pos_x     = req_q.spawn_pos_x;
      mem_wdata.pos_y     = req_q.spawn_pos_y;
      mem_wdata.pos_z     = req_q.spawn_pos_z;
      mem_wdata.vel_x     = req_q.spawn_vel_x;
      mem_wdata.vel_y     = req_q.spawn_vel_y;
      mem_wdata.vel_z     = req_q.spawn_vel_z;
      mem_wdata.rgba      = req_q.spawn_rgba;
      mem_wdata.life      = req_q.spawn_life;
      mem_wdata.init_life = req_q.spawn_life;
      mem_wdata.size      = req_q.spawn_size;
    end else begin
      mem_waddr           = wi[AW-1:0];
      mem_wdata.pos_x     = ent.pos_x;
      mem_wdata.pos_y     = ent.pos_y;
      mem_wdata.pos_z     = ent.pos_z;
      mem_wdata.vel_x     = ent.vel_x;
      mem_wdata.vel_y     = vy;
      mem_wdata.vel_z     = ent.vel_z;
      mem_wdata.rgba      = {ent.rgba[31:8], alpha};
      mem_wdata.life      = life_n;
      mem_wdata.init_life = ent.init_life;
      mem_wdata.size      = 16'(size_prod >> 16);
    end
  end

  // result to load: a status word, or a listed particle straight from the store
  logic              result_load;
  ppu_pkg::result_t  result_next;

  always_comb begin
    result_load = ((state == ppu_pkg::S_RESP) || (state == ppu_pkg::S_LOUT)) && slot_free;
    result_next = '0;
    result_next.live_count  = 7'(count);
    result_next.last_result = 1'b1;
    if (state == ppu_pkg::S_LOUT) begin
      result_next.out_pos_x    = mem_rdata.pos_x;
      result_next.out_pos_y    = mem_rdata.pos_y;
      result_next.out_pos_z    = mem_rdata.pos_z;
      result_next.out_rgba     = mem_rdata.rgba;
      result_next.out_size     = mem_rdata.size;
      result_next.has_particle = 1'b1;
      result_next.last_result  = last_idx;
    end else begin
      result_next.spawn_dropped = drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= result_next;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else begin
      case (state)
        ppu_pkg::S_IDLE: begin
          if (request_valid) begin
            req_q <= request;
            drop  <= 1'b0;
            ri    <= '0;
          end
        end
        ppu_pkg::S_SPAWN: begin
          // drop the particle when the pool is full
          if (count == CW'(POOL_DEPTH)) begin
            drop <= 1'b1;
          end else begin
            count <= count + CW'(1);
          end
        end
        ppu_pkg::S_GRAV: begin
          dv <= 24'((grav_prod + 40'(ppu_pkg::HALF_LSB)) >> 16);
          ri <= '0;
          wi <= '0;
        end
        ppu_pkg::S_LD: begin
          ent    <= mem_rdata;
          vy     <= vy_sat;
          life_n <= life_wide[15:0];
          if (!alive) begin
            ri <= ri + CW'(1);
          end
        end
        ppu_pkg::S_MUL: begin
          dpx <= 25'((px + 41'sd32768) >>> 16);
          dpy <= 25'((py + 41'sd32768) >>> 16);
          dpz <= 25'((pz + 41'sd32768) >>> 16);
        end
        ppu_pkg::S_POS: begin
          ent <= ent_moved;
        end
        ppu_pkg::S_DIV: begin
          if (div_stat.valid) begin
            ratio <= div_ratio;
          end
        end
        ppu_pkg::S_FAC: begin
          alpha  <= 8'((alpha_prod + 25'(ppu_pkg::HALF_LSB)) >> 16);
          factor <= ppu_pkg::SIZE_BASE +
                    17'((slope_prod + 28'(ppu_pkg::HALF_LSB)) >> 16);
        end
        ppu_pkg::S_WR: begin
          wi <= wi + CW'(1);
          ri <= ri + CW'(1);
        end
        ppu_pkg::S_TDONE: begin
          count <= wi;
        end
        ppu_pkg::S_LOUT: begin
          // hold the read data until the output slot frees, then advance
          if (slot_free) begin
            ri <= ri + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(POOL_DEPTH))
    else $error("pool count beyond depth");

  a_wb_order: assert property (@(posedge clk) disable iff (rst)
    (state == ppu_pkg::S_WR) |-> (wi <= ri))
    else $error("write-back index passed read index");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_we_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ppu_pkg::S_SPAWN || state == ppu_pkg::S_WR))
    else $error("store written outside spawn or write-back");

endmodule

FILE: sim/particle_pool_update_test.sv
// Self-checking testbench for the particle pool against a local pool model.
module particle_pool_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = ppu_pkg::POOL_DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_ready;
  ppu_pkg::request_t request = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  ppu_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ppu_pkg::PADDR_W-1:0] paddr = '0;
  logic [ppu_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ppu_pkg::PDATA_W-1:0] prdata;
  logic pready;

  particle_pool_update dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the pool, kept in arrival order like the block.
  ppu_pkg::entry_t  pool_model[DEPTH];
  int               pool_size;
  logic [23:0]      gravity_model;
  ppu_pkg::result_t expected_results[$];
  int               error_count;
  bit               idle_enable;
  int               hold_off_cycles;

  function automatic void enqueue_result(ppu_pkg::result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic logic signed [31:0] move_axis(logic signed [31:0] pos,
                                                   logic signed [23:0] vel,
                                                   logic [15:0] dt);
    longint d;
    longint p;
    d = (longint'(vel) * longint'(dt) + 32768) >>> 16;
    p = longint'(pos) + d;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic ppu_pkg::result_t status_result(bit dropped);
    ppu_pkg::result_t r;
    r = '0;
    r.live_count = pool_size[6:0];
    r.spawn_dropped = dropped;
    r.last_result = 1'b1;
    return r;
  endfunction

  // Work out the results that one accepted request causes and queue them.
  task automatic predict_results(ppu_pkg::request_t req);
    longint unsigned dv, ratio, alpha, factor;
    longint vy, life;
    int dlife, w;
    ppu_pkg::entry_t e;
    ppu_pkg::result_t r;
    case (req.operation)
      ppu_pkg::OP_SPAWN: begin
        if (pool_size >= DEPTH) begin
          enqueue_result(status_result(1'b1));
        end else begin
          e.pos_x = req.spawn_pos_x;
          e.pos_y = req.spawn_pos_y;
          e.pos_z = req.spawn_pos_z;
          e.vel_x = req.spawn_vel_x;
          e.vel_y = req.spawn_vel_y;
          e.vel_z = req.spawn_vel_z;
          e.rgba = req.spawn_rgba;
          e.life = req.spawn_life;
          e.init_life = req.spawn_life;
          e.size = req.spawn_size;
          pool_model[pool_size] = e;
          pool_size++;
          enqueue_result(status_result(1'b0));
        end
      end
      ppu_pkg::OP_TICK: begin
        dv = (longint'(gravity_model) * longint'(req.time_step) + 32768) >> 16;
        dlife = (int'(req.time_step) + 3) >> 2;
        w = 0;
        for (int i = 0; i < pool_size; i++) begin
          e = pool_model[i];
          vy = longint'(e.vel_y) - longint'(dv);
          if (vy < -8388608) vy = -8388608;
          life = longint'(e.life) - dlife;
          if (life > 0) begin
            ratio = (e.init_life != 0) ? ((longint'(life) << 16) / e.init_life) : 0;
            if (ratio > 65536) ratio = 65536;
            alpha = (ratio * 255 + 32768) >> 16;
            factor = 64225 + ((1311 * ratio + 32768) >> 16);
            e.pos_x = move_axis(e.pos_x, e.vel_x, req.time_step);
            e.pos_y = move_axis(e.pos_y, vy[23:0], req.time_step);
            e.pos_z = move_axis(e.pos_z, e.vel_z, req.time_step);
            e.vel_y = vy[23:0];
            e.rgba[7:0] = alpha[7:0];
            e.size = 16'((longint'(e.size) * factor) >> 16);
            e.life = life[15:0];
            pool_model[w] = e;
            w++;
          end
        end
        pool_size = w;
        enqueue_result(status_result(1'b0));
      end
      ppu_pkg::OP_LIST: begin
        if (pool_size == 0) enqueue_result(status_result(1'b0));
        for (int i = 0; i < pool_size; i++) begin
          r = status_result(1'b0);
          r.out_pos_x = pool_model[i].pos_x;
          r.out_pos_y = pool_model[i].pos_y;
          r.out_pos_z = pool_model[i].pos_z;
          r.out_rgba = pool_model[i].rgba;
          r.out_size = pool_model[i].size;
          r.has_particle = 1'b1;
          r.last_result = (i == pool_size - 1);
          enqueue_result(r);
        end
      end
      default: enqueue_result(status_result(1'b0));
    endcase
  endtask

  // Offer one request, sometimes after a random gap, and hold it until accepted.
  task automatic send_request(ppu_pkg::request_t req);
    int gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= req;
    request_valid <= 1'b1;
    do @(posedge clk); while (!request_ready);
    predict_results(req);
  endtask

  // Drop valid and wait for every queued result, then let the block settle.
  task automatic drain;
    request_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gravity(logic [23:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ppu_pkg::ADDR_GRAVITY;
    pwdata <= {8'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gravity_model = value;
  endtask

  function automatic ppu_pkg::request_t make_request(logic [1:0] op);
    ppu_pkg::request_t r;
    r.operation = op;
    r.spawn_pos_x = $urandom;
    r.spawn_pos_y = $urandom;
    r.spawn_pos_z = $urandom;
    r.spawn_vel_x = 24'($urandom);
    r.spawn_vel_y = 24'($urandom);
    r.spawn_vel_z = 24'($urandom);
    r.spawn_rgba = $urandom;
    r.spawn_life = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 2000))
                                               : 16'($urandom);
    r.spawn_size = 16'($urandom);
    // Mostly short steps so particles live a few ticks; sometimes a full one.
    r.time_step = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 3000));
    return r;
  endfunction

  // Pick an operation that keeps the pool small most of the time.
  function automatic logic [1:0] pick_op();
    int n;
    n = $urandom_range(0, 99);
    if (n < 4) return OP_UNUSED;
    if (n < 24) return ppu_pkg::OP_LIST;
    if (n < 50 || pool_size > 12) return ppu_pkg::OP_TICK;
    return ppu_pkg::OP_SPAWN;
  endfunction

  // Receiver: check each result against the oldest expectation, then pick ready.
  int ready_burst;
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", result);
        error_count++;
      end else begin
        automatic ppu_pkg::result_t exp_r = expected_results.pop_front();
        if (result.out_pos_x !== exp_r.out_pos_x) begin
          $error("out_pos_x expected %0d actual %0d", exp_r.out_pos_x, result.out_pos_x);
          error_count++;
        end
        if (result.out_pos_y !== exp_r.out_pos_y) begin
          $error("out_pos_y expected %0d actual %0d", exp_r.out_pos_y, result.out_pos_y);
          error_count++;
        end
        if (result.out_pos_z !== exp_r.out_pos_z) begin
          $error("out_pos_z expected %0d actual %0d", exp_r.out_pos_z, result.out_pos_z);
          error_count++;
        end
        if (result.out_rgba !== exp_r.out_rgba) begin
          $error("out_rgba expected %h actual %h", exp_r.out_rgba, result.out_rgba);
          error_count++;
        end
        if (result.out_size !== exp_r.out_size) begin
          $error("out_size expected %0d actual %0d", exp_r.out_size, result.out_size);
          error_count++;
        end
        if (result.has_particle !== exp_r.has_particle) begin
          $error("has_particle expected %b actual %b",
                 exp_r.has_particle, result.has_particle);
          error_count++;
        end
        if (result.live_count !== exp_r.live_count) begin
          $error("live_count expected %0d actual %0d", exp_r.live_count, result.live_count);
          error_count++;
        end
        if (result.spawn_dropped !== exp_r.spawn_dropped) begin
          $error("spawn_dropped expected %b actual %b",
                 exp_r.spawn_dropped, result.spawn_dropped);
          error_count++;
        end
        if (result.last_result !== exp_r.last_result) begin
          $error("last_result expected %b actual %b",
                 exp_r.last_result, result.last_result);
          error_count++;
        end
      end
    end
    // Long hold-off first, then random stall bursts while idling is on.
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      result_ready <= 1'b0;
    end else if (ready_burst > 0) begin
      ready_burst--;
      result_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      ready_burst = $urandom_range(0, 15);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Extremes of every field, each operation and the named corner cases.
  task automatic test_directed;
    ppu_pkg::request_t r;
    send_request(make_request(ppu_pkg::OP_LIST));   // lists one status when the pool is empty
    r = make_request(ppu_pkg::OP_SPAWN);
    r.spawn_pos_x = 32'sh7fffffff;
    r.spawn_pos_y = 32'sh80000000;
    r.spawn_pos_z = 32'sh7fffffff;
    r.spawn_vel_x = 24'sh7fffff;
    r.spawn_vel_y = 24'sh800000;
    r.spawn_vel_z = 24'sh800000;
    r.spawn_rgba = 32'hffffffff;
    r.spawn_life = 16'hffff;
    r.spawn_size = 16'hffff;
    send_request(r);
    r.spawn_pos_x = 32'sh80000000;
    r.spawn_pos_y = 32'sh7fffffff;
    r.spawn_pos_z = 32'sh80000000;
    r.spawn_vel_x = 24'sh800000;
    r.spawn_vel_y = 24'sh7fffff;
    r.spawn_vel_z = 24'sh7fffff;
    r.spawn_rgba = 32'h0;
    r.spawn_size = 16'h0;
    send_request(r);
    r.spawn_life = 16'd0;                           // zero initial life
    send_request(r);
    r.spawn_life = 16'd1;
    send_request(r);
    send_request(make_request(ppu_pkg::OP_LIST));
    r = make_request(ppu_pkg::OP_TICK);
    r.time_step = 16'd0;                            // zero step still removes dead
    send_request(r);
    send_request(make_request(ppu_pkg::OP_LIST));
    r.time_step = 16'd1;
    send_request(r);
    send_request(make_request(ppu_pkg::OP_LIST));
    r.time_step = 16'hffff;
    send_request(r);
    send_request(make_request(ppu_pkg::OP_LIST));
    send_request(make_request(OP_UNUSED));
    r = make_request(OP_UNUSED);
    r.operation = OP_UNUSED;
    send_request(r);
    repeat (4) send_request(make_request(ppu_pkg::OP_TICK));
    send_request(make_request(ppu_pkg::OP_LIST));
    drain();
  endtask

  // Fill the pool, push spawns past full, list all, then age everything out.
  task automatic test_pool_full;
    ppu_pkg::request_t r;
    while (pool_size < DEPTH) send_request(make_request(ppu_pkg::OP_SPAWN));
    repeat (3) send_request(make_request(ppu_pkg::OP_SPAWN));
    send_request(make_request(ppu_pkg::OP_LIST));
    r = make_request(ppu_pkg::OP_TICK);
    r.time_step = 16'hffff;
    repeat (5) send_request(r);
    send_request(make_request(ppu_pkg::OP_LIST));
    drain();
  endtask

  // Hold the receiver off while the sender keeps offering, so the block backs up.
  task automatic test_back_pressure;
    hold_off_cycles = 600;
    repeat (6) send_request(make_request(ppu_pkg::OP_SPAWN));
    repeat (10) send_request(make_request(pick_op()));
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_request(make_request(pick_op()));
    drain();
  endtask

  initial begin
    error_count = 0;
    pool_size = 0;
    gravity_model = ppu_pkg::GRAVITY_RESET;
    idle_enable = 1'b1;
    hold_off_cycles = 0;
    ready_burst = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_gravity(24'd0);
    test_random(30);
    write_gravity(24'hffffff);
    test_directed();
    test_pool_full();
    write_gravity(24'($urandom));
    test_back_pressure();
    test_random(50);
    write_gravity(ppu_pkg::GRAVITY_RESET);
    test_random(50);
    // Last part runs with both sides always ready.
    idle_enable = 1'b0;
    test_random(30);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
sv/ppu_pkg.sv
sv/ppu_mem.sv
sv/ppu_div.sv
sv/particle_pool_update.sv
sim/particle_pool_update_test.sv
